// File: sv/vmt_pkg.sv
// ----------------------------------------------------------------------------
// vmt_pkg
// Shared types and constants of the 4x4 vector-matrix transform engine.
// ----------------------------------------------------------------------------
package vmt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int DIM           = 4;
    localparam int IDX_W         = $clog2(DIM);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [DATA_W-1:0] t_word;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_XFORM = 1'b1
    } t_op;

    // One queued command; a load keeps its entry value in data[0].
    typedef struct packed {
        t_op                     op;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        t_word [DIM-1:0]         data;
    } t_qentry;

    typedef struct packed {
        logic valid;
        logic full;
    } t_qstat;

    typedef struct packed {
        logic pop;
        logic xform;
    } t_pop;

endpackage

// File: sv/vmt_in_if.sv
// ----------------------------------------------------------------------------
// vmt_in_if
// Command channel: matrix entry loads and vector transforms.
// ----------------------------------------------------------------------------
interface vmt_in_if import vmt_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [IDX_W-1:0]  entry_row;
    logic [IDX_W-1:0]  entry_col;
    t_word             entry_value;
    t_word             vec_x;
    t_word             vec_y;
    t_word             vec_z;
    t_word             vec_w;

    modport source (
        output valid, cmd, entry_row, entry_col, entry_value,
               vec_x, vec_y, vec_z, vec_w,
        input  ready
    );

    modport sink (
        input  valid, cmd, entry_row, entry_col, entry_value,
               vec_x, vec_y, vec_z, vec_w,
        output ready
    );

endinterface

// File: sv/vmt_out_if.sv
// ----------------------------------------------------------------------------
// vmt_out_if
// Result channel: one transformed vector per beat.
// ----------------------------------------------------------------------------
interface vmt_out_if import vmt_pkg::*; ();

    logic  valid;
    logic  ready;
    t_word out_x;
    t_word out_y;
    t_word out_z;
    t_word out_w;

    modport source (
        output valid, out_x, out_y, out_z, out_w,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z, out_w,
        output ready
    );

endinterface

// File: sv/vmt_front.sv
// ----------------------------------------------------------------------------
// vmt_front
// Accepts command beats, decodes them and packs them into queue entries.
// ----------------------------------------------------------------------------
module vmt_front import vmt_pkg::*; (
    vmt_in_if.sink  i_in,
    input  t_qstat  i_qstat,
    output logic    o_push,
    output t_qentry o_entry
);

    // Take a beat whenever the queue has room
    assign i_in.ready = !i_qstat.full;
    assign o_push     = i_in.valid && !i_qstat.full;

    // Classify the command and pack its payload
    always_comb begin
        o_entry.row = i_in.entry_row;
        o_entry.col = i_in.entry_col;
        if (i_in.cmd) begin
            o_entry.op      = OP_XFORM;
            o_entry.data[0] = i_in.vec_x;
            o_entry.data[1] = i_in.vec_y;
            o_entry.data[2] = i_in.vec_z;
            o_entry.data[3] = i_in.vec_w;
        end else begin
            o_entry.op      = OP_LOAD;
            o_entry.data    = '0;
            o_entry.data[0] = i_in.entry_value;
        end
    end

endmodule

// File: sv/vmt_queue.sv
// ----------------------------------------------------------------------------
// vmt_queue
// Short FIFO that decouples command decode from execution.
// ----------------------------------------------------------------------------
module vmt_queue import vmt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_qentry i_entry,
    input  logic    i_pop,
    output t_qentry o_entry,
    output t_qstat  o_stat
);

    localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

    t_qentry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_entry      = r_mem[r_rd_ptr];
    assign o_stat.valid = (r_count != '0);
    assign o_stat.full  = (r_count == FULL_CNT);

endmodule

// File: sv/vmt_back.sv
// ----------------------------------------------------------------------------
// vmt_back
// Holds the matrix and executes queued commands: loads write one entry,
// transforms run one column per cycle through four multipliers, a sum
// stage and a shift-and-saturate stage into the output register.
// ----------------------------------------------------------------------------
module vmt_back import vmt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_qstat  i_qstat,
    input  t_qentry i_entry,
    output t_pop    o_pop,
    vmt_out_if.source o_out
);

    localparam logic [IDX_W-1:0] LAST_COL = IDX_W'(DIM - 1);
    localparam int               HI_LSB   = FRAC_BITS + DATA_W - 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic [IDX_W-1:0]          r_col;
    t_word                     r_vec  [DIM];
    t_word                     r_mat  [DIM][DIM];
    logic                      r_p1_valid;
    logic [IDX_W-1:0]          r_p1_col;
    logic signed [PROD_W-1:0]  r_prod [DIM];
    logic                      r_p2_valid;
    logic [IDX_W-1:0]          r_p2_col;
    logic signed [SUM_W-1:0]   r_sum;
    t_word                     r_acc  [DIM-1];
    logic                      r_out_valid;
    t_word                     r_out  [DIM];

    logic                      pop;
    logic                      pop_load;
    logic                      pop_xform;
    logic                      last_beat;
    logic signed [PROD_W-1:0]  prod   [DIM];
    logic signed [SUM_W-1:0]   sum;
    logic [SUM_W-HI_LSB-1:0]   sum_hi;
    t_word                     sat;

    // Pop when idle; a transform also needs the output register free
    assign pop       = (r_state == ST_IDLE) && i_qstat.valid &&
                       ((i_entry.op == OP_LOAD) || !r_out_valid || o_out.ready);
    assign pop_load  = pop && (i_entry.op == OP_LOAD);
    assign pop_xform = pop && (i_entry.op == OP_XFORM);
    assign o_pop.pop   = pop;
    assign o_pop.xform = pop_xform;

    // Write one matrix entry per load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    r_mat[r][c] <= '0;
                end
            end
        end else if (pop_load) begin
            r_mat[i_entry.row][i_entry.col] <= i_entry.data[0];
        end
    end

    // Latch the vector and step the column counter
    always_ff @(posedge i_clk) begin
        if (pop_xform) begin
            for (int r = 0; r < DIM; r++) begin
                r_vec[r] <= i_entry.data[r];
            end
            r_col <= '0;
        end else if (r_state == ST_ISSUE) begin
            r_col <= r_col + 1'b1;
        end
    end

    // Multiply the vector by the current column
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            prod[r] = r_vec[r] * r_mat[r][r_col];
        end
    end

    // Sum the four exact products
    always_comb begin
        sum = '0;
        for (int r = 0; r < DIM; r++) begin
            sum = sum + {{(SUM_W - PROD_W){r_prod[r][PROD_W-1]}}, r_prod[r]};
        end
    end

    // Shift out the fraction and clamp to the word range
    assign sum_hi = r_sum[SUM_W-1:HI_LSB];
    always_comb begin
        if ((&sum_hi) || !(|sum_hi)) begin
            sat = r_sum[HI_LSB:FRAC_BITS];
        end else if (r_sum[SUM_W-1]) begin
            sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    // Product and sum pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_p1_valid <= (r_state == ST_ISSUE);
            r_p2_valid <= r_p1_valid;
        end
        r_p1_col <= r_col;
        r_p2_col <= r_p1_col;
        r_sum    <= sum;
        for (int r = 0; r < DIM; r++) begin
            r_prod[r] <= prod[r];
        end
    end

    // Collect the leading columns of the result
    always_ff @(posedge i_clk) begin
        if (r_p2_valid && (r_p2_col != LAST_COL)) begin
            r_acc[r_p2_col] <= sat;
        end
    end

    assign last_beat = r_p2_valid && (r_p2_col == LAST_COL);

    // Sequence control
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (pop_xform) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (r_col == LAST_COL) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (last_beat) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (last_beat) begin
                r_out_valid <= 1'b1;
                for (int c = 0; c < DIM - 1; c++) begin
                    r_out[c] <= r_acc[c];
                end
                r_out[DIM-1] <= sat;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.out_x = r_out[0];
    assign o_out.out_y = r_out[1];
    assign o_out.out_z = r_out[2];
    assign o_out.out_w = r_out[3];

endmodule

// File: sv/vector_matrix_transform_4x4.sv
// ----------------------------------------------------------------------------
// vector_matrix_transform_4x4
// Row vector times a stored 4x4 matrix in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries commands. cmd = 0 loads entry_value into the matrix at
//   entry_row/entry_col and gives no result; cmd = 1 transforms the vector
//   vec_x..vec_w. o_out carries one result beat per transform, element c
//   being sum over r of v[r]*M[r][c], shifted right by FRAC_BITS (toward
//   minus infinity) and saturated to 32 bits.
//   Commands pass a two-entry queue and execute in order.
//   A load writes its matrix entry as it leaves the queue. A transform
//   issues one column per cycle through four 32x32 multipliers, then
//   product, sum and saturate register stages into the output register;
//   the next command leaves the queue only once that result is in the
//   output register, so transforms do not overlap.
//   Reset (i_rst_n low, synchronous) empties the queue, drops any result
//   and clears the matrix to zero.
//   While o_out stalls, the result holds in the output register; loads
//   ahead of the next transform still execute, that transform waits for
//   the register, and i_in keeps accepting until the queue is full.
// ----------------------------------------------------------------------------
module vector_matrix_transform_4x4 import vmt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vmt_in_if.sink    i_in,
    vmt_out_if.source o_out
);

    logic    q_push;
    t_qentry q_in;
    t_qentry q_head;
    t_qstat  q_stat;
    t_pop    b_pop;

    vmt_front u_front (
        .i_in    (i_in),
        .i_qstat (q_stat),
        .o_push  (q_push),
        .o_entry (q_in)
    );

    vmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (b_pop.pop),
        .o_entry (q_head),
        .o_stat  (q_stat)
    );

    vmt_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (q_stat),
        .i_entry (q_head),
        .o_pop   (b_pop),
        .o_out   (o_out)
    );

    // Execution never pulls from an empty queue
    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_pop.pop |-> q_stat.valid)
        else $error("pop from empty command queue");

    // Every transform delivers a valid result on o_out
    a_xform_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_pop.xform |-> ##7 o_out.valid)
        else $error("transform result missing");

    // A result appears only as the outcome of a transform
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(b_pop.xform, 7))
        else $error("result without a transform");

endmodule
